// ===== src/cbfe_pkg.sv =====
// Shared types, codes and constants of the chunked block fetch engine.
`timescale 1ns / 1ps

package cbfe_pkg;

    // Descriptor ring depth default
    localparam int RING_DEPTH_DEF = 10;

    // Result queue depth (power of two, at least two)
    localparam int OQ_DEPTH = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SAVE_MAX_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_CHUNK_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT_S     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUESTS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAVE_ENABLED      = 3'd4;

    // Register reset values
    localparam logic [31:0] SAVE_MAX_SIZE_RST     = 32'd65536;
    localparam logic [15:0] READ_CHUNK_LENGTH_RST = 16'd512;
    localparam logic [7:0]  ACK_TIMEOUT_S_RST     = 8'd5;
    localparam logic [7:0]  MAX_REQUESTS_RST      = 8'd60;

    // Length of the "#!AMR\n" file header in bytes
    localparam logic [15:0] HDR_LEN = 16'd6;

    // Input item kinds
    localparam logic [1:0] KIND_POLL  = 2'd0;
    localparam logic [1:0] KIND_DESC  = 2'd1;
    localparam logic [1:0] KIND_CHUNK = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Result actions
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_READ_REQ  = 3'd1;
    localparam logic [2:0] ACT_SAVE_HDR  = 3'd2;
    localparam logic [2:0] ACT_SAVE_DATA = 3'd3;
    localparam logic [2:0] ACT_FINISHED  = 3'd4;

    // Descriptor: block number over block length
    localparam int DESC_W = 24;

    typedef struct packed {
        logic [31:0] file_size;
        logic [15:0] request_length;
        logic [31:0] offset;
        logic [7:0]  request_block;
        logic [2:0]  action;
        logic        last;
    } t_result;

    // Results produced by one accepted transaction
    typedef struct packed {
        logic    valid;
        logic    dual;
        t_result first;
        t_result second;
    } t_res_push;

endpackage

// ===== src/chunked_block_fetch_engine_core.sv =====
// Top level of the chunked block fetch engine: stream ports, control and result queue.
`timescale 1ns / 1ps
// Latency: results of a transaction sit in the output queue the cycle after it is accepted.
// Throughput: one input transaction per cycle; a chunk that needs a header save yields two
//   results, and the output side drains one result per cycle from a four-entry queue.
// Input ready drops while fewer than two queue entries are free.
// Reset (synchronous, active low) clears control state and loads register defaults;
//   the descriptor RAM is not cleared and needs no clearing pass.

module chunked_block_fetch_engine_core #(
    parameter int RING_DEPTH = cbfe_pkg::RING_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // elapsed_s[15:0], block_index[23:16], length[39:24], header_present[40], zero pad
    input  logic [47:0]                     i_s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                      i_s_axis_tuser,
    // Result stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // action[2:0], request_block[10:3], offset[42:11], request_length[58:43],
    // file_size[90:59], zero pad
    output logic [95:0]                     o_m_axis_tdata,
    output logic                            o_m_axis_tlast,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [cbfe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cbfe_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    import cbfe_pkg::*;

    logic      in_accept;
    t_res_push push;
    t_result   out_res;
    logic      q_ready;

    // A transaction is taken only when the queue can hold both of its possible results
    assign o_s_axis_tready = q_ready;
    assign in_accept       = i_s_axis_tvalid && q_ready;

    cbfe_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_kind           (i_s_axis_tuser),
        .i_elapsed_s      (i_s_axis_tdata[15:0]),
        .i_block_index    (i_s_axis_tdata[23:16]),
        .i_length         (i_s_axis_tdata[39:24]),
        .i_header_present (i_s_axis_tdata[40]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_push           (push)
    );

    // Output queue decouples the result side so input keeps flowing under short stalls
    cbfe_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_ready     (q_ready),
        .o_valid     (o_m_axis_tvalid),
        .o_data      (out_res),
        .i_pop_ready (i_m_axis_tready)
    );

    // Pack the result fields, lowest field in the lowest bits
    assign o_m_axis_tdata = {5'd0,
                             out_res.file_size,
                             out_res.request_length,
                             out_res.offset,
                             out_res.request_block,
                             out_res.action};
    assign o_m_axis_tlast = out_res.last;

endmodule

// ===== src/cbfe_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module cbfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/cbfe_outq.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle.
`timescale 1ns / 1ps

module cbfe_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cbfe_pkg::t_res_push i_push,
    output logic                o_ready,
    output logic                o_valid,
    output cbfe_pkg::t_result   o_data,
    input  logic                i_pop_ready
);

    import cbfe_pkg::*;

    localparam int IDX_W = $clog2(OQ_DEPTH);

    t_result          r_q [OQ_DEPTH];
    logic [IDX_W-1:0] r_head;
    logic [IDX_W:0]   r_count;
    logic [IDX_W-1:0] n_head;
    logic [IDX_W:0]   n_count;
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] tail_next;
    logic [IDX_W:0]   push_n;
    logic             pop;

    assign pop       = (r_count != '0) && i_pop_ready;
    assign tail      = r_head + r_count[IDX_W-1:0];
    assign tail_next = tail + IDX_W'(1);

    always_comb begin
        push_n = '0;
        if (i_push.valid) begin
            push_n = i_push.dual ? (IDX_W+1)'(2) : (IDX_W+1)'(1);
        end
        n_head  = pop ? r_head + IDX_W'(1) : r_head;
        n_count = r_count + push_n - (IDX_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_q[tail] <= i_push.first;
        end
        if (i_push.valid && i_push.dual) begin
            r_q[tail_next] <= i_push.second;
        end
    end

    // Keep room for a two-result transaction
    assign o_ready = (r_count <= (IDX_W+1)'(OQ_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_data  = r_q[r_head];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (IDX_W+1)'(OQ_DEPTH))
        else $error("result queue count above depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> r_count <= (IDX_W+1)'(OQ_DEPTH - 2))
        else $error("results pushed without room for two");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push.valid) |=> r_count == $past(r_count) - (IDX_W+1)'(1))
        else $error("result queue count lost track on pop");

endmodule

// ===== src/cbfe_ctrl.sv =====
// Fetch control: descriptor ring in RAM, poll state machine, chunk accounting.
`timescale 1ns / 1ps

module cbfe_ctrl #(
    parameter int RING_DEPTH = cbfe_pkg::RING_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [1:0]                       i_kind,
    input  logic [15:0]                      i_elapsed_s,
    input  logic [7:0]                       i_block_index,
    input  logic [15:0]                      i_length,
    input  logic                             i_header_present,
    input  logic                             i_cfg_we,
    input  logic [cbfe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cbfe_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output cbfe_pkg::t_res_push              o_push
);

    import cbfe_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GET  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_END  = 2'd3;

    // Configuration registers
    logic [31:0] r_save_max_size;
    logic [15:0] r_read_chunk_length;
    logic [7:0]  r_ack_timeout_s;
    logic [7:0]  r_max_requests;
    logic        r_save_enabled;

    // Fetch state
    logic [1:0]        r_state, n_state;
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [DESC_W-1:0] r_cur_desc, n_cur_desc;
    logic [15:0]       r_bytes_got, n_bytes_got;
    logic [15:0]       r_exp_len, n_exp_len;
    logic              r_end_flag, n_end_flag;
    logic              r_ack_flag, n_ack_flag;
    logic [7:0]        r_req_count, n_req_count;
    logic [7:0]        r_timeout_left, n_timeout_left;
    logic [31:0]       r_file_offset, n_file_offset;
    logic [31:0]       r_file_bytes, n_file_bytes;

    // Ring RAM and write forwarding
    logic              ram_we;
    logic [DESC_W-1:0] ram_wdata;
    logic [DESC_W-1:0] ram_rdata;
    logic              r_fwd_hit;
    logic [DESC_W-1:0] r_fwd_data;
    logic [DESC_W-1:0] ring_desc;

    // Datapath helpers
    logic [7:0]  cur_blk;
    logic [15:0] cur_len;
    logic [7:0]  tl_dec;
    logic [31:0] room;
    logic        hdr_ins;
    logic [31:0] fo_base;
    logic [32:0] fo_sum;
    logic [31:0] fo_data;
    logic [32:0] fb_hdr_sum;
    logic [31:0] fb_hdr;
    logic [16:0] fb_addend;
    logic [32:0] fb_sum;
    logic [31:0] fb_data;
    logic [16:0] bg_sum;

    t_result res_first;
    t_result res_second;
    logic    res_dual;

    cbfe_ram #(
        .WIDTH (DESC_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (ram_wdata),
        .i_raddr (n_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign ram_we    = i_accept && (i_kind == KIND_DESC);
    assign ram_wdata = {i_block_index, i_length};
    assign ring_desc = r_fwd_hit ? r_fwd_data : ram_rdata;

    assign cur_blk = r_cur_desc[23:16];
    assign cur_len = r_cur_desc[15:0];

    // Saturating datapath terms
    always_comb begin
        tl_dec = ({8'd0, r_timeout_left} <= i_elapsed_s) ? 8'd0
                                                         : r_timeout_left - i_elapsed_s[7:0];
        room = (r_save_max_size >= {16'd0, r_exp_len}) ?
               r_save_max_size - {16'd0, r_exp_len} : 32'd0;

        hdr_ins    = (r_file_offset == 32'd0) && !i_header_present;
        fo_base    = hdr_ins ? {16'd0, HDR_LEN} : r_file_offset;
        fo_sum     = {1'b0, fo_base} + {17'd0, i_length};
        fo_data    = fo_sum[32] ? '1 : fo_sum[31:0];
        fb_hdr_sum = {1'b0, r_file_bytes} + {17'd0, HDR_LEN};
        fb_hdr     = fb_hdr_sum[32] ? '1 : fb_hdr_sum[31:0];
        fb_addend  = {1'b0, i_length} + (hdr_ins ? {1'b0, HDR_LEN} : 17'd0);
        fb_sum     = {1'b0, r_file_bytes} + {16'd0, fb_addend};
        fb_data    = fb_sum[32] ? '1 : fb_sum[31:0];
        bg_sum     = {1'b0, r_bytes_got} + {1'b0, i_length};
    end

    // Next state and results of the accepted transaction
    always_comb begin
        n_state        = r_state;
        n_wr_ptr       = r_wr_ptr;
        n_rd_ptr       = r_rd_ptr;
        n_cur_desc     = r_cur_desc;
        n_bytes_got    = r_bytes_got;
        n_exp_len      = r_exp_len;
        n_end_flag     = r_end_flag;
        n_ack_flag     = r_ack_flag;
        n_req_count    = r_req_count;
        n_timeout_left = r_timeout_left;
        n_file_offset  = r_file_offset;
        n_file_bytes   = r_file_bytes;

        res_first            = '0;
        res_first.action     = ACT_NONE;
        res_first.file_size  = r_file_bytes;
        res_first.last       = 1'b1;
        res_second           = '0;
        res_second.last      = 1'b1;
        res_dual             = 1'b0;

        if (i_accept) begin
            unique case (i_kind)
                KIND_POLL: begin
                    n_timeout_left = tl_dec;
                    unique case (r_state)
                        ST_IDLE: begin
                            if (r_rd_ptr != r_wr_ptr) begin
                                n_cur_desc  = ring_desc;
                                n_bytes_got = 16'd0;
                                n_end_flag  = 1'b0;
                                n_req_count = 8'd0;
                                n_state     = ST_GET;
                            end
                        end
                        ST_GET: begin
                            n_ack_flag                = 1'b0;
                            n_exp_len                 = r_read_chunk_length;
                            res_first.action          = ACT_READ_REQ;
                            res_first.request_block   = cur_blk;
                            res_first.offset          = {16'd0, r_bytes_got};
                            res_first.request_length  = r_read_chunk_length;
                            n_timeout_left            = r_ack_timeout_s;
                            if (r_req_count != 8'hFF) begin
                                n_req_count = r_req_count + 8'd1;
                            end
                            n_state = ST_WAIT;
                        end
                        ST_WAIT: begin
                            if (r_ack_flag || (tl_dec == 8'd0)) begin
                                if ((r_bytes_got >= cur_len) || r_end_flag) begin
                                    n_state = ST_END;
                                end else begin
                                    n_state = (r_file_offset < room) ? ST_GET : ST_END;
                                end
                            end else if (r_req_count > r_max_requests) begin
                                // give up on this block
                                n_req_count = 8'd0;
                                n_state     = ST_END;
                            end
                        end
                        ST_END: begin
                            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
                            n_state  = ST_IDLE;
                            res_first.action        = ACT_FINISHED;
                            res_first.request_block = cur_blk;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
                KIND_DESC: begin
                    if (r_wr_ptr == PTR_LAST) begin
                        n_wr_ptr = '0;
                        // overwrite the oldest entry
                        if (r_rd_ptr == '0) begin
                            n_rd_ptr = PTR_W'(1);
                        end
                    end else begin
                        n_wr_ptr = r_wr_ptr + PTR_W'(1);
                    end
                end
                KIND_CHUNK: begin
                    n_bytes_got = bg_sum[16] ? 16'hFFFF : bg_sum[15:0];
                    n_end_flag  = (i_length < r_exp_len);
                    n_ack_flag  = 1'b1;
                    if (r_save_enabled) begin
                        n_file_offset = fo_data;
                        n_file_bytes  = fb_data;
                    end else begin
                        n_file_offset = fo_base;
                        n_file_bytes  = hdr_ins ? fb_hdr : r_file_bytes;
                    end
                    if (r_save_enabled && hdr_ins) begin
                        res_dual                  = 1'b1;
                        res_first.action          = ACT_SAVE_HDR;
                        res_first.offset          = r_file_offset;
                        res_first.request_length  = HDR_LEN;
                        res_first.file_size       = fb_hdr;
                        res_first.last            = 1'b0;
                        res_second.action         = ACT_SAVE_DATA;
                        res_second.offset         = fo_base;
                        res_second.request_length = i_length;
                        res_second.file_size      = fb_data;
                    end else if (r_save_enabled) begin
                        res_first.action          = ACT_SAVE_DATA;
                        res_first.offset          = fo_base;
                        res_first.request_length  = i_length;
                        res_first.file_size       = fb_data;
                    end else begin
                        res_first.file_size       = n_file_bytes;
                    end
                end
                KIND_CLEAR: begin
                    n_wr_ptr            = '0;
                    n_rd_ptr            = '0;
                    n_state             = ST_IDLE;
                    n_bytes_got         = 16'd0;
                    n_exp_len           = 16'd0;
                    n_end_flag          = 1'b0;
                    n_ack_flag          = 1'b0;
                    n_file_offset       = 32'd0;
                    n_file_bytes        = 32'd0;
                    res_first.file_size = 32'd0;
                end
                default: n_state = r_state;
            endcase
        end
    end

    always_comb begin
        o_push.valid  = i_accept;
        o_push.dual   = res_dual;
        o_push.first  = res_first;
        o_push.second = res_second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_cur_desc     <= '0;
            r_bytes_got    <= '0;
            r_exp_len      <= '0;
            r_end_flag     <= 1'b0;
            r_ack_flag     <= 1'b0;
            r_req_count    <= '0;
            r_timeout_left <= '0;
            r_file_offset  <= '0;
            r_file_bytes   <= '0;
            r_fwd_hit      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_wr_ptr       <= n_wr_ptr;
            r_rd_ptr       <= n_rd_ptr;
            r_cur_desc     <= n_cur_desc;
            r_bytes_got    <= n_bytes_got;
            r_exp_len      <= n_exp_len;
            r_end_flag     <= n_end_flag;
            r_ack_flag     <= n_ack_flag;
            r_req_count    <= n_req_count;
            r_timeout_left <= n_timeout_left;
            r_file_offset  <= n_file_offset;
            r_file_bytes   <= n_file_bytes;
            // forward a write that lands on the entry being read
            r_fwd_hit      <= ram_we && (r_wr_ptr == n_rd_ptr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= ram_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_save_max_size     <= SAVE_MAX_SIZE_RST;
            r_read_chunk_length <= READ_CHUNK_LENGTH_RST;
            r_ack_timeout_s     <= ACK_TIMEOUT_S_RST;
            r_max_requests      <= MAX_REQUESTS_RST;
            r_save_enabled      <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAVE_MAX_SIZE:     r_save_max_size     <= i_cfg_wdata;
                CFG_READ_CHUNK_LENGTH: r_read_chunk_length <= i_cfg_wdata[15:0];
                CFG_ACK_TIMEOUT_S:     r_ack_timeout_s     <= i_cfg_wdata[7:0];
                CFG_MAX_REQUESTS:      r_max_requests      <= i_cfg_wdata[7:0];
                CFG_SAVE_ENABLED:      r_save_enabled      <= i_cfg_wdata[0];
                default:               r_save_enabled      <= r_save_enabled;
            endcase
        end
    end

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr <= PTR_LAST) && (r_rd_ptr <= PTR_LAST))
        else $error("ring pointer beyond ring depth");

    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_kind == KIND_POLL) && (r_state == ST_END)) |=> r_state == ST_IDLE)
        else $error("poll in end state did not return to idle");

    a_dual_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.dual |-> (o_push.valid && (i_kind == KIND_CHUNK) && r_save_enabled))
        else $error("two results outside a saved chunk");

endmodule
